// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the RTL of the row hash block.
// Depends on a clock named clock and a synchronous reset named reset in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define GRH_ASSERT(name, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Expression must never be true outside reset.
`define GRH_ASSERT_NEVER(name, expr, msg) \
   `GRH_ASSERT(name, !(expr), msg)

`endif

// ===== rtl/core/grh_pkg.sv =====
// Shared types, constants and tables of the graph row hash block.
// No dependencies.
package grh_pkg;

   localparam int GRH_ROW_WIDTH  = 64;
   localparam int GRH_NUM_GLYPHS = 16;
   localparam int GRH_SYM_W      = 6;
   localparam int GRH_INDEX_W    = $clog2(GRH_NUM_GLYPHS);

   localparam logic [63:0] GRH_FOLD_MUL_A = 64'd1237;
   localparam logic [63:0] GRH_FOLD_MUL_B = 64'd1233457;
   localparam logic [63:0] GRH_SEED_A_ADD = 64'd2;
   localparam logic [63:0] GRH_SEED_A_MUL = 64'd13;
   localparam logic [63:0] GRH_SEED_B_MUL = 64'd17;

   typedef struct packed {
      logic [63:0] row_word;
      logic        first_row;
      logic        last_row;
      logic [6:0]  vertex_count;
      logic [6:0]  hydrogen_count;
      logic [7:0]  bond_count;
   } grh_req_type;

   typedef struct packed {
      logic [6:0] glyph_char;
      logic       final_char;
   } grh_rsp_type;

   typedef logic [GRH_SYM_W-1:0] grh_sym_type;
   typedef grh_sym_type [GRH_NUM_GLYPHS-1:0] grh_syms_type;

   typedef struct packed {
      logic         valid;
      grh_syms_type syms;
   } grh_load_type;

   typedef struct packed {
      logic busy;
      logic done;
   } grh_emit_stat_type;

   function automatic logic [19:0] grh_fold_tab_a(input logic [1:0] sel);
      logic [19:0] val;
      unique case (sel)
         2'd0: val = 20'h37541;
         2'd1: val = 20'h61532;
         2'd2: val = 20'h05257;
         2'd3: val = 20'h26416;
         default: val = '0;
      endcase
      return val;
   endfunction

   function automatic logic [19:0] grh_fold_tab_b(input logic [1:0] sel);
      logic [19:0] val;
      unique case (sel)
         2'd0: val = 20'h06532;
         2'd1: val = 20'h70236;
         2'd2: val = 20'h35523;
         2'd3: val = 20'h62437;
         default: val = '0;
      endcase
      return val;
   endfunction

   // A-Z, a-z, 0-9, '@', '%'
   function automatic logic [6:0] grh_sym_to_ascii(input grh_sym_type sym);
      logic [6:0] code;
      priority if (sym < 6'd26) begin
         code = 7'h41 + 7'(sym);
      end else if (sym < 6'd52) begin
         code = 7'h61 + 7'(sym - 6'd26);
      end else if (sym < 6'd62) begin
         code = 7'h30 + 7'(sym - 6'd52);
      end else if (sym == 6'd62) begin
         code = 7'h40;
      end else begin
         code = 7'h25;
      end
      return code;
   endfunction

endpackage

// ===== rtl/core/graph_row_hash_to_glyphs.sv =====
// Top level of the graph row hash block: fold stage and glyph emitter.
// Depends on grh_pkg, grh_fold and grh_emit.
//
// Takes one adjacency row per cycle while req_stall is low. Each row is registered,
// then folded from that register into two 64-bit accumulators by a constant
// multiply-add, so rows stream at one per cycle while not stalled. A last row loads
// its 16 glyphs from the fold result into a glyph buffer register, and its first
// glyph is offered once that buffer holds them; the glyphs leave one item per cycle
// while rsp_stall is low, as rows of the next graph keep folding. A second last row
// arriving before the buffer has drained stalls the input until the sixteenth glyph
// of the previous code is taken.
module graph_row_hash_to_glyphs import grh_pkg::*; #(
   parameter int ROW_WIDTH = GRH_ROW_WIDTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  grh_req_type req_item,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output grh_rsp_type rsp_item
);

   grh_load_type      load;
   grh_emit_stat_type emit_stat;

   grh_fold #(
      .ROW_WIDTH(ROW_WIDTH)
   ) u_fold (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_item (req_item),
      .emit_stat(emit_stat),
      .load     (load)
   );

   grh_emit u_emit (
      .clock    (clock),
      .reset    (reset),
      .load     (load),
      .emit_stat(emit_stat),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_item (rsp_item)
   );

endmodule

// ===== rtl/core/grh_fold.sv =====
// Input register and accumulator fold stage of the graph row hash block.
// Depends on grh_pkg.
module grh_fold import grh_pkg::*; #(
   parameter int ROW_WIDTH = GRH_ROW_WIDTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  grh_req_type       req_item,
   input  grh_emit_stat_type emit_stat,
   output grh_load_type      load
);

   localparam logic [6:0] RowWidthW = 7'(ROW_WIDTH);

   logic                 pipe_valid_ff, pipe_valid_in;
   grh_req_type          pipe_item_ff;
   logic [63:0]          acc_a_ff, acc_a_in;
   logic [63:0]          acc_b_ff, acc_b_in;
   logic [6:0]           shift_ff, shift_in;
   logic                 hold;
   logic                 advance;
   logic [ROW_WIDTH-1:0] row_masked, row_aligned;
   logic [63:0]          x;
   logic [63:0]          seed_a, seed_b, base_a, base_b;

   // a last row waits here while the glyph buffer still drains
   assign hold = pipe_valid_ff && pipe_item_ff.last_row && emit_stat.busy && !emit_stat.done;
   assign req_stall = hold;
   assign advance = pipe_valid_ff && !hold;
   assign pipe_valid_in = hold ? pipe_valid_ff : req_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         pipe_valid_ff <= 1'b0;
      end else begin
         pipe_valid_ff <= pipe_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !hold) begin
         pipe_item_ff <= req_item;
      end
   end

   always_comb begin
      if (pipe_item_ff.first_row) begin
         shift_in = (pipe_item_ff.vertex_count >= RowWidthW) ? 7'd0
                    : RowWidthW - pipe_item_ff.vertex_count;
      end else begin
         shift_in = shift_ff;
      end
   end

   assign row_masked  = pipe_item_ff.row_word[ROW_WIDTH-1:0];
   assign row_aligned = row_masked >> shift_in;
   assign x           = 64'(row_aligned);

   assign seed_a = GRH_SEED_A_ADD
                   + GRH_SEED_A_MUL * (64'(pipe_item_ff.hydrogen_count) + 64'd1);
   assign seed_b = 64'(pipe_item_ff.vertex_count)
                   + GRH_SEED_B_MUL * 64'(pipe_item_ff.bond_count);
   assign base_a = pipe_item_ff.first_row ? seed_a : acc_a_ff;
   assign base_b = pipe_item_ff.first_row ? seed_b : acc_b_ff;

   assign acc_a_in = base_a * GRH_FOLD_MUL_A + (x ^ 64'(grh_fold_tab_a(x[1:0])));
   assign acc_b_in = base_b * GRH_FOLD_MUL_B + (x ^ 64'(grh_fold_tab_b(x[1:0])));

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_a_ff <= '0;
         acc_b_ff <= '0;
         shift_ff <= '0;
      end else if (advance) begin
         acc_a_ff <= acc_a_in;
         acc_b_ff <= acc_b_in;
         shift_ff <= shift_in;
      end
   end

   assign load.valid = advance && pipe_item_ff.last_row;

   always_comb begin
      for (int k = 0; k < GRH_NUM_GLYPHS / 2; k++) begin
         load.syms[k] = acc_a_in[8*k +: GRH_SYM_W];
         load.syms[k + GRH_NUM_GLYPHS / 2] = acc_b_in[8*k +: GRH_SYM_W];
      end
   end

endmodule

// ===== rtl/core/grh_emit.sv =====
// Glyph buffer and output sequencing of the graph row hash block.
// Depends on grh_pkg and assert_macros.svh.
`include "assert_macros.svh"
module grh_emit import grh_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  grh_load_type      load,
   output grh_emit_stat_type emit_stat,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output grh_rsp_type       rsp_item
);

   localparam logic [GRH_INDEX_W-1:0] LastIndex = GRH_INDEX_W'(GRH_NUM_GLYPHS - 1);

   logic                   busy_ff, busy_in;
   logic [GRH_INDEX_W-1:0] index_ff, index_in;
   grh_syms_type           syms_ff;
   logic                   done;

   assign done = busy_ff && !rsp_stall && (index_ff == LastIndex);

   always_comb begin
      if (load.valid) begin
         busy_in  = 1'b1;
         index_in = '0;
      end else begin
         busy_in  = busy_ff && !done;
         index_in = (busy_ff && !rsp_stall) ? index_ff + 1'b1 : index_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         index_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         index_ff <= index_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load.valid) begin
         syms_ff <= load.syms;
      end
   end

   assign emit_stat.busy      = busy_ff;
   assign emit_stat.done      = done;
   assign rsp_valid           = busy_ff;
   assign rsp_item.glyph_char = grh_sym_to_ascii(syms_ff[index_ff]);
   assign rsp_item.final_char = (index_ff == LastIndex);

   `GRH_ASSERT_NEVER(a_load_over_busy, load.valid && busy_ff && !done, "buffer overwritten")
   `GRH_ASSERT(a_idle_index, !busy_ff |-> (index_ff == '0), "index not cleared when idle")
   `GRH_ASSERT(a_drain_end, (done && !load.valid) |=> !busy_ff, "buffer busy after final item")

endmodule
